FILE: hw/rtl/csbr_pkg.sv
// csbr_pkg: shared constants for the b-spline segment rasteriser
// no dependencies; imported by every module of the block

package csbr_pkg;

  // t is held in q0.16
  localparam int T_BITS = 16;
  // sample count width, counts up to 64
  localparam int NW = 7;
  // width of the 65536 / n quotient
  localparam int QW = T_BITS + 1;
  // binary search start bit for the sample count
  localparam logic [2:0] SRCH_TOP = 3'd6;
  // depth of the segment queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

FILE: hw/rtl/csbr_front.sv
// csbr_front: point window, coefficients, sample count and t step set-up
// depends on csbr_pkg; feeds segment requests to csbr_queue

module csbr_front #(
  parameter int COORD_BITS = 12,
  parameter int MAX_SEGMENT_SAMPLES = 64,
  localparam int CW = COORD_BITS + 4,
  localparam int EW = 8 * CW + 2 * csbr_pkg::NW + csbr_pkg::QW
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output logic                         push_valid,
  input  logic                         push_ready,
  output logic [EW-1:0]                push_data
);
  import csbr_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int D2W = 2 * COORD_BITS + 3;

  typedef enum logic [2:0] {
    F_IDLE, F_DIST, F_SRCH, F_DIV, F_PUSH
  } fstate_t;

  fstate_t                      state_r;
  logic signed [COORD_BITS-1:0] wx_r [4];
  logic signed [COORD_BITS-1:0] wy_r [4];
  logic [1:0]                   seen_r;
  logic [D2W-1:0]               d2_r;
  logic [NW-1:0]                n_r;
  logic [2:0]                   bit_r;
  logic signed [CW-1:0]         ax_r [4];
  logic signed [CW-1:0]         ay_r [4];
  logic [4:0]                   div_cnt_r;
  logic [NW-1:0]                rem_r;
  logic [QW-1:0]                quo_r;

  logic                         accept;
  logic signed [DW-1:0]         dx, dy;
  logic signed [2*DW-1:0]       dx2, dy2;
  logic [D2W-1:0]               d2_nxt;
  logic [NW-1:0]                cand, n_nxt;
  logic [2*NW-1:0]              cand_sq;
  logic                         cand_ok;
  logic [NW:0]                  rem_sh;
  logic                         rem_ge;
  logic signed [CW-1:0]         x0, x1, x2, x3, y0, y1, y2, y3;

  assign in_ready   = (state_r == F_IDLE);
  assign accept     = in_valid && in_ready;
  assign push_valid = (state_r == F_PUSH);
  assign push_data  = {rem_r, quo_r, n_r,
                       ay_r[3], ay_r[2], ay_r[1], ay_r[0],
                       ax_r[3], ax_r[2], ax_r[1], ax_r[0]};

  // squared distance between the two middle points
  always_comb begin
    dx     = DW'(wx_r[2]) - DW'(wx_r[1]);
    dy     = DW'(wy_r[2]) - DW'(wy_r[1]);
    dx2    = dx * dx;
    dy2    = dy * dy;
    d2_nxt = D2W'($unsigned(dx2)) + D2W'($unsigned(dy2));
  end

  // one bit of the integer square root per cycle
  always_comb begin
    cand    = n_r | (NW'(1) << bit_r);
    cand_sq = cand * cand;
    cand_ok = (cand <= NW'(MAX_SEGMENT_SAMPLES)) && (D2W'(cand_sq) <= d2_r);
    n_nxt   = cand_ok ? cand : n_r;
  end

  // restoring divide of 65536 by the sample count
  always_comb begin
    rem_sh = {rem_r, (div_cnt_r == 5'd16)};
    rem_ge = (rem_sh >= {1'b0, n_r});
  end

  // window points widened for the six-times-scaled coefficients
  always_comb begin
    x0 = CW'(wx_r[0]); x1 = CW'(wx_r[1]); x2 = CW'(wx_r[2]); x3 = CW'(wx_r[3]);
    y0 = CW'(wy_r[0]); y1 = CW'(wy_r[1]); y2 = CW'(wy_r[2]); y3 = CW'(wy_r[3]);
  end

  // state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      seen_r  <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        wx_r[i] <= '0;
        wy_r[i] <= '0;
      end
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            for (int i = 0; i < 3; i++) begin
              wx_r[i] <= wx_r[i+1];
              wy_r[i] <= wy_r[i+1];
            end
            wx_r[3] <= point_x;
            wy_r[3] <= point_y;
            if (seen_r != 2'd2) begin
              seen_r <= seen_r + 2'd1;
            end else begin
              state_r <= F_DIST;
            end
          end
        end
        F_DIST: begin
          d2_r    <= d2_nxt;
          n_r     <= '0;
          bit_r   <= SRCH_TOP;
          ax_r[0] <= CW'(-x0 + 3 * x1 - 3 * x2 + x3);
          ax_r[1] <= CW'(3 * x0 - 6 * x1 + 3 * x2);
          ax_r[2] <= CW'(-3 * x0 + 3 * x2);
          ax_r[3] <= CW'(x0 + 4 * x1 + x2);
          ay_r[0] <= CW'(-y0 + 3 * y1 - 3 * y2 + y3);
          ay_r[1] <= CW'(3 * y0 - 6 * y1 + 3 * y2);
          ay_r[2] <= CW'(-3 * y0 + 3 * y2);
          ay_r[3] <= CW'(y0 + 4 * y1 + y2);
          state_r <= F_SRCH;
        end
        F_SRCH: begin
          n_r   <= n_nxt;
          bit_r <= bit_r - 3'd1;
          if (bit_r == 3'd0) begin
            div_cnt_r <= 5'd16;
            rem_r     <= '0;
            quo_r     <= '0;
            state_r   <= (n_nxt == '0) ? F_IDLE : F_DIV;
          end
        end
        F_DIV: begin
          rem_r     <= rem_ge ? NW'(rem_sh - {1'b0, n_r}) : NW'(rem_sh);
          quo_r     <= {quo_r[QW-2:0], rem_ge};
          div_cnt_r <= div_cnt_r - 5'd1;
          if (div_cnt_r == 5'd0) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // a pushed segment always has a sample count within the cap
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (n_r != '0 && n_r <= NW'(MAX_SEGMENT_SAMPLES)))
    else $error("segment pushed with bad sample count");

  // a segment is only closed once three points have been taken into the window
  a_dist_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_DIST) |-> (seen_r == 2'd2))
    else $error("segment closed before window filled");

  // the remainder of the divide stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) |-> (rem_r < n_r))
    else $error("divide remainder out of range");

endmodule

FILE: hw/rtl/csbr_queue.sv
// csbr_queue: short segment queue between front and back
// depends on csbr_pkg for its depth

module csbr_queue #(
  parameter int EW = 94
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [EW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [EW-1:0] pop_data
);
  import csbr_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [EW-1:0]   mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            push, pop;

  assign push_ready = (count_r != CNTW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNTW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNTW'(1);
      end
    end
  end

  // fill count never passes the depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(QUEUE_DEPTH))
    else $error("queue overfilled");

  // pointers agree with the fill count when empty
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree when empty");

  // a pop without a push lowers the fill count by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - CNTW'(1)))
    else $error("queue count not decremented on pop");

endmodule

FILE: hw/rtl/csbr_back.sv
// csbr_back: horner evaluation of each segment, one sample at a time
// depends on csbr_pkg; takes segment requests from csbr_queue

module csbr_back #(
  parameter int COORD_BITS = 12,
  localparam int CW = COORD_BITS + 4,
  localparam int EW = 8 * CW + 2 * csbr_pkg::NW + csbr_pkg::QW
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  logic [EW-1:0]                pop_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] sample_x,
  output logic signed [COORD_BITS-1:0] sample_y,
  output logic                         segment_last
);
  import csbr_pkg::*;

  localparam int UW = COORD_BITS + 6;
  localparam int PW = UW + T_BITS + 1;
  localparam int KD = UW + 3;
  localparam int MD = (2 ** KD + 5) / 6;
  localparam logic [UW:0] M6 = (UW + 1)'(MD);
  localparam logic signed [UW-1:0] LO_W = -(UW'(2 ** (COORD_BITS - 1)));
  localparam logic signed [UW-1:0] HI_W = UW'(2 ** (COORD_BITS - 1) - 1);
  localparam int OFF_N = 8 * CW;

  typedef enum logic [2:0] {
    B_IDLE, B_H1, B_H2, B_H3, B_DIV, B_EMIT
  } bstate_t;

  bstate_t                      state_r;
  logic signed [CW-1:0]         ax_r [4];
  logic signed [CW-1:0]         ay_r [4];
  logic [NW-1:0]                n_r, rn_r, r_r, j_r;
  logic [QW-1:0]                qn_r, t_r;
  logic signed [UW-1:0]         ux_r, uy_r, qx_r, qy_r;
  logic                         out_valid_r, last_r;
  logic signed [COORD_BITS-1:0] sx_r, sy_r;

  logic signed [UW-1:0]         ux_src, uy_src, cx, cy, ux_nxt, uy_nxt;
  logic signed [T_BITS:0]       tt;
  logic signed [PW-1:0]         mx, my;
  logic [UW-1:0]                abs_x, abs_y, qa_x, qa_y;
  logic [2*UW:0]                px, py;
  logic signed [UW-1:0]         satx, saty;
  logic                         emit, last;
  logic [NW:0]                  r_sum;
  logic                         r_wrap;

  assign pop_ready    = (state_r == B_IDLE);
  assign out_valid    = out_valid_r;
  assign sample_x     = sx_r;
  assign sample_y     = sy_r;
  assign segment_last = last_r;
  assign emit         = (state_r == B_EMIT) && (!out_valid_r || out_ready);
  assign last         = (j_r == n_r - NW'(1));

  // one horner step per axis: u = c + floor(u * t / 65536)
  always_comb begin
    tt     = $signed({1'b0, t_r[T_BITS-1:0]});
    ux_src = (state_r == B_H1) ? UW'(ax_r[0]) : ux_r;
    uy_src = (state_r == B_H1) ? UW'(ay_r[0]) : uy_r;
    case (state_r)
      B_H1:    begin cx = UW'(ax_r[1]); cy = UW'(ay_r[1]); end
      B_H2:    begin cx = UW'(ax_r[2]); cy = UW'(ay_r[2]); end
      default: begin cx = UW'(ax_r[3]); cy = UW'(ay_r[3]); end
    endcase
    mx     = ux_src * tt;
    my     = uy_src * tt;
    ux_nxt = cx + mx[UW+T_BITS-1:T_BITS];
    uy_nxt = cy + my[UW+T_BITS-1:T_BITS];
  end

  // divide by six toward zero via reciprocal multiply
  always_comb begin
    abs_x = ux_r[UW-1] ? UW'(-ux_r) : UW'(ux_r);
    abs_y = uy_r[UW-1] ? UW'(-uy_r) : UW'(uy_r);
    px    = abs_x * M6;
    py    = abs_y * M6;
    qa_x  = UW'(px[2*UW:KD]);
    qa_y  = UW'(py[2*UW:KD]);
  end

  // clamp to the coordinate range
  always_comb begin
    satx = (qx_r < LO_W) ? LO_W : ((qx_r > HI_W) ? HI_W : qx_r);
    saty = (qy_r < LO_W) ? LO_W : ((qy_r > HI_W) ? HI_W : qy_r);
  end

  // next t from the quotient and remainder of 65536 / n
  always_comb begin
    r_sum  = {1'b0, r_r} + {1'b0, rn_r};
    r_wrap = (r_sum >= {1'b0, n_r});
  end

  // state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            for (int i = 0; i < 4; i++) begin
              ax_r[i] <= pop_data[i*CW +: CW];
              ay_r[i] <= pop_data[(i+4)*CW +: CW];
            end
            n_r     <= pop_data[OFF_N +: NW];
            qn_r    <= pop_data[OFF_N+NW +: QW];
            rn_r    <= pop_data[OFF_N+NW+QW +: NW];
            j_r     <= '0;
            t_r     <= '0;
            r_r     <= '0;
            state_r <= B_H1;
          end
        end
        B_H1, B_H2, B_H3: begin
          ux_r    <= ux_nxt;
          uy_r    <= uy_nxt;
          state_r <= (state_r == B_H1) ? B_H2 : ((state_r == B_H2) ? B_H3 : B_DIV);
        end
        B_DIV: begin
          qx_r    <= ux_r[UW-1] ? -$signed(qa_x) : $signed(qa_x);
          qy_r    <= uy_r[UW-1] ? -$signed(qa_y) : $signed(qa_y);
          state_r <= B_EMIT;
        end
        B_EMIT: begin
          if (emit) begin
            sx_r        <= satx[COORD_BITS-1:0];
            sy_r        <= saty[COORD_BITS-1:0];
            last_r      <= last;
            j_r         <= j_r + NW'(1);
            r_r         <= r_wrap ? NW'(r_sum - {1'b0, n_r}) : NW'(r_sum);
            t_r         <= t_r + qn_r + QW'(r_wrap);
            state_r     <= last ? B_IDLE : B_H1;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // sample index stays inside the segment while busy
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |-> (j_r < n_r))
    else $error("sample index past segment end");

  // t stays below one while a segment is evaluated
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_H1) |-> (t_r[QW-1] == 1'b0))
    else $error("t overflowed q0.16");

  // a last sample always returns the back end to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (state_r == B_IDLE))
    else $error("back end busy after last sample");

endmodule

FILE: hw/rtl/cubic_bspline_segment_rasterizer_unit.sv
// cubic_bspline_segment_rasterizer_unit: top level of the b-spline rasteriser
// depends on csbr_pkg, csbr_front, csbr_queue and csbr_back
//
// channel | dir | tdata (low bit up)        | tlast
// in_     | in  | point_x, point_y          | -
// out_    | out | sample_x, sample_y        | segment_last
//
// a point is shifted into the window; a closing point then goes through
// the front (distance, 7-step square root, 17-step divide, push).
// each sample goes through the back (three horner multiplies, the
// divide by six, the output register, which can stall on out_tready);
// a segment is taken from the queue only while the back is idle.
// reset is synchronous and active low and clears the window to zeros.
// the two-entry queue lets the front prepare the next segment while the
// back is stalled on out_tready.

module cubic_bspline_segment_rasterizer_unit #(
  parameter int COORD_BITS = 12,
  parameter int MAX_SEGMENT_SAMPLES = 64,
  localparam int DBW = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [DBW-1:0] in_tdata,   // point_x, point_y
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [DBW-1:0] out_tdata,  // sample_x, sample_y
  output logic           out_tlast
);
  import csbr_pkg::*;

  localparam int CW = COORD_BITS + 4;
  localparam int EW = 8 * CW + 2 * NW + QW;

  logic                         push_valid, push_ready, pop_valid, pop_ready;
  logic [EW-1:0]                push_data, pop_data;
  logic signed [COORD_BITS-1:0] sample_x, sample_y;

  // front: window, coefficients and segment set-up
  csbr_front #(
    .COORD_BITS          (COORD_BITS),
    .MAX_SEGMENT_SAMPLES (MAX_SEGMENT_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .point_x    ($signed(in_tdata[COORD_BITS-1:0])),
    .point_y    ($signed(in_tdata[2*COORD_BITS-1:COORD_BITS])),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // segment queue
  csbr_queue #(
    .EW (EW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: per-sample evaluation
  csbr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .sample_x     (sample_x),
    .sample_y     (sample_y),
    .segment_last (out_tlast)
  );

  // pack the output sample
  assign out_tdata = DBW'({sample_y, sample_x});

endmodule

FILE: bench/csbr_checker.sv
// csbr_checker: watches both streams of the b-spline rasteriser, predicts the
// samples of every closed segment and compares them with what the block emits
// depends on nothing but the port widths of cubic_bspline_segment_rasterizer_unit

module csbr_checker #(
  parameter int COORD_BITS = 12,
  parameter int MAX_SEGMENT_SAMPLES = 64,
  parameter int DBW = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tready,
  input  logic [DBW-1:0] in_tdata,
  input  logic           out_tvalid,
  input  logic           out_tready,
  input  logic [DBW-1:0] out_tdata,
  input  logic           out_tlast,
  output int             fail_count,
  output int             pending,
  output int             samples_seen,
  output int             segments_seen
);

  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic                  last;
  } sample_t;

  // window of control points, oldest at index 0
  longint win_x [4];
  longint win_y [4];
  int     fill_level;
  sample_t sample_queue [$];

  assign pending = sample_queue.size();

  function automatic longint floor_t(longint v);
    if (v >= 0) return v / 65536;
    return -((-v + 65535) / 65536);
  endfunction

  // horner evaluation of one axis, six times scaled, divided by six, then saturated
  function automatic logic [COORD_BITS-1:0] curve_axis(longint c0, longint c1,
                                                       longint c2, longint c3,
                                                       longint t);
    longint u;
    longint lo;
    longint hi;
    lo = -(longint'(1) <<< (COORD_BITS - 1));
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    u = c1 + floor_t(c0 * t);
    u = c2 + floor_t(u * t);
    u = c3 + floor_t(u * t);
    u = u / 6;
    if (u < lo) u = lo;
    if (u > hi) u = hi;
    return u[COORD_BITS-1:0];
  endfunction

  // shift in one point and queue the samples of the segment it closes
  task automatic add_point(logic [DBW-1:0] d);
    longint dx, dy, dist2, t;
    longint cx [4];
    longint cy [4];
    int n;
    sample_t s;
    for (int i = 0; i < 3; i++) begin
      win_x[i] = win_x[i+1];
      win_y[i] = win_y[i+1];
    end
    win_x[3] = longint'($signed(d[COORD_BITS-1:0]));
    win_y[3] = longint'($signed(d[2*COORD_BITS-1:COORD_BITS]));
    if (fill_level < 2) begin
      fill_level++;
      return;
    end
    dx = win_x[2] - win_x[1];
    dy = win_y[2] - win_y[1];
    dist2 = dx * dx + dy * dy;
    n = 0;
    while (n < MAX_SEGMENT_SAMPLES && longint'(n + 1) * longint'(n + 1) <= dist2) n++;
    if (n == 0) return;
    cx[0] = -win_x[0] + 3 * win_x[1] - 3 * win_x[2] + win_x[3];
    cx[1] = 3 * win_x[0] - 6 * win_x[1] + 3 * win_x[2];
    cx[2] = -3 * win_x[0] + 3 * win_x[2];
    cx[3] = win_x[0] + 4 * win_x[1] + win_x[2];
    cy[0] = -win_y[0] + 3 * win_y[1] - 3 * win_y[2] + win_y[3];
    cy[1] = 3 * win_y[0] - 6 * win_y[1] + 3 * win_y[2];
    cy[2] = -3 * win_y[0] + 3 * win_y[2];
    cy[3] = win_y[0] + 4 * win_y[1] + win_y[2];
    for (int j = 0; j < n; j++) begin
      t = (longint'(j) * 65536) / n;
      s.sx = curve_axis(cx[0], cx[1], cx[2], cx[3], t);
      s.sy = curve_axis(cy[0], cy[1], cy[2], cy[3], t);
      s.last = (j == n - 1);
      sample_queue.push_back(s);
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        win_x[i] = 0;
        win_y[i] = 0;
      end
      fill_level = 0;
      sample_queue.delete();
      fail_count <= 0;
      samples_seen <= 0;
      segments_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        samples_seen <= samples_seen + 1;
        if (out_tlast) segments_seen <= segments_seen + 1;
        if (sample_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected sample x=%0d y=%0d last=%0b",
                     $signed(out_tdata[COORD_BITS-1:0]),
                     $signed(out_tdata[2*COORD_BITS-1:COORD_BITS]), out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          want = sample_queue.pop_front();
          if (want.sx !== out_tdata[COORD_BITS-1:0] ||
              want.sy !== out_tdata[2*COORD_BITS-1:COORD_BITS] ||
              want.last !== out_tlast) begin
            if (fail_count < 10)
              $display("sample mismatch: want x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                       $signed(want.sx), $signed(want.sy), want.last,
                       $signed(out_tdata[COORD_BITS-1:0]),
                       $signed(out_tdata[2*COORD_BITS-1:COORD_BITS]), out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) add_point(in_tdata);
    end
  end

endmodule

FILE: bench/tb_cubic_bspline_segment_rasterizer_unit.sv
// tb_cubic_bspline_segment_rasterizer_unit: drives control points into the
// rasteriser under several idle/stall mixes; csbr_checker does the checking
// depends on cubic_bspline_segment_rasterizer_unit and csbr_checker

module tb_cubic_bspline_segment_rasterizer_unit;

  localparam int CB = 12;
  localparam int DBW = 24;
  localparam int CYCLE_LIMIT = 900000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [DBW-1:0] in_tdata = '0;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [DBW-1:0] out_tdata;
  logic           out_tlast;
  int fail_count, pending, samples_seen, segments_seen;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;
  int cycles = 0;
  int points_sent = 0;

  always #1 clk = ~clk;

  cubic_bspline_segment_rasterizer_unit uut (.*);

  csbr_checker #(.COORD_BITS(CB), .MAX_SEGMENT_SAMPLES(64), .DBW(DBW)) check (.*);

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one point and hold it until it is taken
  task automatic send_point(int x, int y);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {y[CB-1:0], x[CB-1:0]};
    do @(posedge clk); while (!in_tready);
    points_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // mostly short hops so segments stay small, with some long jumps
  task automatic random_points(int count);
    int x, y;
    x = 0;
    y = 0;
    repeat (count) begin
      case ($urandom_range(9))
        0: begin
          x = $urandom_range(4095) - 2048;
          y = $urandom_range(4095) - 2048;
        end
        1: ;
        default: begin
          x = x + $urandom_range(40) - 20;
          y = y + $urandom_range(40) - 20;
          if (x > 2047) x = 2047;
          if (x < -2048) x = -2048;
          if (y > 2047) y = 2047;
          if (y < -2048) y = -2048;
        end
      endcase
      send_point(x, y);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: filling points, zero distance, extremes, saturation, short hops
    send_point(0, 0);
    send_point(0, 0);
    send_point(0, 0);
    send_point(3, 4);
    send_point(3, 4);
    send_point(2047, 2047);
    send_point(-2048, -2048);
    send_point(2047, -2048);
    send_point(-2048, 2047);
    send_point(2047, 2047);
    send_point(2047, 2047);
    send_point(2046, 2047);
    send_point(-1, -1);
    send_point(0, 1);
    send_point(-2048, -2048);
    send_point(-2048, -2048);
    send_point(-2047, -2048);
    send_point(1365, -1366);
    send_point(-1366, 1365);
    send_point(5, 0);
    // sender waits for every sample
    drain();

    // long receiver hold-off while points keep coming
    hold_off <= 600;
    random_points(20);
    drain();

    random_points(90);
    idle_pct = 48;
    random_points(90);
    idle_pct = 0;
    stall_pct = 48;
    random_points(90);
    idle_pct = 27;
    stall_pct = 27;
    random_points(90);
    drain();

    $display("sent %0d points, checked %0d samples over %0d segments",
             points_sent, samples_seen, segments_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
